// File: rtl/pif_pkg.sv
// pif_pkg: shared constants, codes and types of the packet-to-flit injector.
// Depends on nothing; every rtl file refers to it by scoped names.
package pif_pkg;

	localparam int NUM_VC     = 4;
	localparam int MAX_WPF    = 8;
	localparam int MAX_FLITS  = 64;

	localparam int WORD_W     = 64;
	localparam int ID_W       = 32;
	localparam int CH_W       = 2;
	localparam int SLOT_W     = 3;
	localparam int KIND_W     = 2;
	localparam int STAT_W     = 2;
	localparam int CNT_W      = 7;
	localparam int WPF_W      = 4;
	localparam int ACT_W      = 3;
	localparam int FIDX_W     = 6;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [KIND_W-1:0] KIND_HEAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MIDDLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TAIL   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ATOM   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_STALL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DROP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_VC_MODE         = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_CHANNEL   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WORDS_PER_FLIT  = 8'd3;

	typedef struct packed {
		logic              vc_mode;
		logic [CH_W-1:0]   fixed_channel;
		logic [ACT_W-1:0]  active_channels;
		logic [WPF_W-1:0]  words_per_flit;
	} cfg_t;

	// One classified input beat: expands into 'beats' result beats.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   number;
		logic [CH_W-1:0]   channel;
		logic [SLOT_W-1:0] slot;
		logic [STAT_W-1:0] status;
		logic [WPF_W-1:0]  beats;
	} cmd_t;

endpackage

// File: rtl/pif_front.sv
// pif_front: packet sequencing, VC choice and classification of input beats.
// Depends on pif_pkg; produces one pif_pkg::cmd_t per accepted beat.
module pif_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pif_pkg::cfg_t                  cfg,
	input  logic                           accept,
	input  logic [pif_pkg::WORD_W-1:0]     data_word,
	input  logic                           first_word,
	input  logic [pif_pkg::CNT_W-1:0]      flit_count,
	input  logic [pif_pkg::ID_W-1:0]       start_flit_id,
	input  logic [pif_pkg::NUM_VC-1:0]     full_mask,
	output pif_pkg::cmd_t                  cmd
);

	logic                          in_packet_q;
	logic [pif_pkg::FIDX_W-1:0]    flit_index_q;
	logic [pif_pkg::SLOT_W-1:0]    word_index_q;
	logic [pif_pkg::CNT_W-1:0]     total_flits_q;
	logic [pif_pkg::ID_W-1:0]      base_id_q;
	logic [pif_pkg::CH_W-1:0]      cur_ch_q;
	logic [pif_pkg::CH_W-1:0]      last_ch_q;

	logic                          in_packet_d;
	logic [pif_pkg::FIDX_W-1:0]    flit_index_d;
	logic [pif_pkg::SLOT_W-1:0]    word_index_d;
	logic [pif_pkg::CNT_W-1:0]     total_flits_d;
	logic [pif_pkg::ID_W-1:0]      base_id_d;
	logic [pif_pkg::CH_W-1:0]      cur_ch_d;
	logic [pif_pkg::CH_W-1:0]      last_ch_d;

	logic [pif_pkg::WPF_W-1:0]     wpf;
	logic [pif_pkg::CNT_W-1:0]     count_eff;
	logic [pif_pkg::ACT_W-1:0]     n_act;
	logic                          found_rr;
	logic [pif_pkg::CH_W-1:0]      ch_rr;
	logic [pif_pkg::ACT_W-1:0]     cand_sum;
	logic [pif_pkg::CH_W-1:0]      cand;
	logic                          found;
	logic [pif_pkg::CH_W-1:0]      ch_sel;
	logic [pif_pkg::WPF_W-1:0]     word_next;
	logic [pif_pkg::CNT_W-1:0]     flit_next;

	// Reduce a small sum modulo the active VC count (1 to 4).
	function automatic logic [pif_pkg::CH_W-1:0] mod_n(
		input logic [pif_pkg::ACT_W-1:0] s,
		input logic [pif_pkg::ACT_W-1:0] n
	);
		logic [pif_pkg::CH_W-1:0] r;
		case (n)
			3'd1: r = 2'd0;
			3'd2: r = {1'b0, s[0]};
			3'd3: begin
				case (s)
					3'd0, 3'd3, 3'd6: r = 2'd0;
					3'd1, 3'd4, 3'd7: r = 2'd1;
					default:          r = 2'd2;
				endcase
			end
			default: r = s[1:0];
		endcase
		return r;
	endfunction

	always_comb begin
		if (cfg.words_per_flit == '0)
			wpf = 4'd1;
		else if (cfg.words_per_flit > 4'(pif_pkg::MAX_WPF))
			wpf = 4'(pif_pkg::MAX_WPF);
		else
			wpf = cfg.words_per_flit;

		if (flit_count == '0)
			count_eff = 7'd1;
		else if (flit_count > 7'(pif_pkg::MAX_FLITS))
			count_eff = 7'(pif_pkg::MAX_FLITS);
		else
			count_eff = flit_count;

		if (cfg.active_channels == '0)
			n_act = 3'd1;
		else if (cfg.active_channels > 3'(pif_pkg::NUM_VC))
			n_act = 3'(pif_pkg::NUM_VC);
		else
			n_act = cfg.active_channels;
	end

	// Round-robin search, starting after the last VC used.
	always_comb begin
		found_rr = 1'b0;
		ch_rr    = '0;
		cand_sum = '0;
		cand     = '0;
		for (int k = 0; k < pif_pkg::NUM_VC; k++) begin
			cand_sum = {1'b0, last_ch_q} + 3'(k) + 3'd1;
			cand     = mod_n(cand_sum, n_act);
			if ((3'(k) < n_act) && !found_rr && !full_mask[cand]) begin
				found_rr = 1'b1;
				ch_rr    = cand;
			end
		end
	end

	always_comb begin
		ch_sel    = cfg.vc_mode ? ch_rr : cfg.fixed_channel;
		found     = cfg.vc_mode ? found_rr : !full_mask[cfg.fixed_channel];
		word_next = {1'b0, word_index_q} + 4'd1;
		flit_next = {1'b0, flit_index_q} + 7'd1;

		in_packet_d   = in_packet_q;
		flit_index_d  = flit_index_q;
		word_index_d  = word_index_q;
		total_flits_d = total_flits_q;
		base_id_d     = base_id_q;
		cur_ch_d      = cur_ch_q;
		last_ch_d     = last_ch_q;

		cmd        = '0;
		cmd.beats  = 4'd1;
		cmd.status = pif_pkg::STAT_DROP;

		if (!in_packet_q) begin
			if (first_word) begin
				if (!found) begin
					cmd.status = pif_pkg::STAT_STALL;
				end else begin
					cmd.word    = data_word;
					cmd.kind    = (count_eff == 7'd1) ? pif_pkg::KIND_ATOM
					                                   : pif_pkg::KIND_HEAD;
					cmd.number  = start_flit_id;
					cmd.channel = ch_sel;
					cmd.status  = pif_pkg::STAT_OK;
					cmd.beats   = wpf;
					if (cfg.vc_mode)
						last_ch_d = ch_rr;
					cur_ch_d      = ch_sel;
					base_id_d     = start_flit_id;
					total_flits_d = count_eff;
					word_index_d  = '0;
					in_packet_d   = (count_eff > 7'd1);
					flit_index_d  = (count_eff > 7'd1) ? 6'd1 : 6'd0;
				end
			end
		end else if (!first_word) begin
			if (word_index_q == '0 && full_mask[cur_ch_q]) begin
				cmd.status = pif_pkg::STAT_STALL;
			end else begin
				cmd.word    = data_word;
				cmd.kind    = (flit_next >= total_flits_q) ? pif_pkg::KIND_TAIL
				                                          : pif_pkg::KIND_MIDDLE;
				cmd.number  = base_id_q + 32'(flit_index_q);
				cmd.channel = cur_ch_q;
				cmd.slot    = word_index_q;
				cmd.status  = pif_pkg::STAT_OK;
				if (word_next >= wpf) begin
					word_index_d = '0;
					if (flit_next >= total_flits_q) begin
						in_packet_d  = 1'b0;
						flit_index_d = '0;
					end else begin
						flit_index_d = flit_next[pif_pkg::FIDX_W-1:0];
					end
				end else begin
					word_index_d = word_next[pif_pkg::SLOT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q   <= 1'b0;
			flit_index_q  <= '0;
			word_index_q  <= '0;
			total_flits_q <= '0;
			base_id_q     <= '0;
			cur_ch_q      <= '0;
			last_ch_q     <= '0;
		end else if (accept) begin
			in_packet_q   <= in_packet_d;
			flit_index_q  <= flit_index_d;
			word_index_q  <= word_index_d;
			total_flits_q <= total_flits_d;
			base_id_q     <= base_id_d;
			cur_ch_q      <= cur_ch_d;
			last_ch_q     <= last_ch_d;
		end
	end

endmodule

// File: rtl/pif_queue.sv
// pif_queue: short command queue between the front and back halves.
// Depends on pif_pkg for the cmd_t entry type.
module pif_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pif_pkg::cmd_t  wr_data,
	output logic           full,
	input  logic           rd_en,
	output pif_pkg::cmd_t  rd_data,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	pif_pkg::cmd_t     entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				level_q <= level_q + 1'b1;
			else if (do_rd && !do_wr)
				level_q <= level_q - 1'b1;
		end
	end

endmodule

// File: rtl/pif_back.sv
// pif_back: expands queued commands into result beats on a registered output.
// Depends on pif_pkg; reads commands from pif_queue.
module pif_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pif_pkg::cmd_t                q_data,
	input  logic                         q_empty,
	output logic                         q_rd,
	input  logic                         pop,
	output logic                         empty,
	output logic [pif_pkg::WORD_W-1:0]   flit_word,
	output logic [pif_pkg::KIND_W-1:0]   flit_kind,
	output logic [pif_pkg::ID_W-1:0]     flit_number,
	output logic [pif_pkg::CH_W-1:0]     channel,
	output logic [pif_pkg::SLOT_W-1:0]   word_slot,
	output logic [pif_pkg::STAT_W-1:0]   status,
	output logic                         last_of_run
);

	pif_pkg::cmd_t                 cur_q;
	logic                          valid_q;
	logic [pif_pkg::SLOT_W-1:0]    beat_q;
	logic                          is_last;
	logic                          done;

	assign is_last = ({1'b0, beat_q} + 4'd1) == cur_q.beats;
	assign done    = pop && valid_q && is_last;
	assign q_rd    = !q_empty && (!valid_q || done);

	assign empty       = !valid_q;
	assign flit_word   = (beat_q == '0) ? cur_q.word : '0;
	assign flit_kind   = cur_q.kind;
	assign flit_number = cur_q.number;
	assign channel     = cur_q.channel;
	assign word_slot   = cur_q.slot + beat_q;
	assign status      = cur_q.status;
	assign last_of_run = is_last;

	always_ff @(posedge clk) begin
		if (q_rd)
			cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
			beat_q  <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (pop && valid_q) begin
			beat_q <= beat_q + 1'b1;
		end
	end

endmodule

// File: rtl/packet_to_flit_injector.sv
// packet_to_flit_injector: top level; holds the configuration registers and
// joins pif_front, pif_queue and pif_back. Depends on pif_pkg.
//
//  channel   | handshake             | beat carries
//  ----------+-----------------------+--------------------------------------------
//  input     | push / full           | data_word, first_word, flit_count,
//            |                       | start_flit_id, full_mask
//  result    | empty / pop           | flit_word, flit_kind, flit_number, channel,
//            |                       | word_slot, status, last_of_run
//  config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Cycles: one input beat per cycle while full is low; its command is written into the
// queue and then loaded into the output register. A head or atom flit yields words_per_flit
// result beats, one per pop; any other input beat yields one, so result beats set the rate.
// Result-side stalls back up into the QUEUE_DEPTH-entry command queue; full rises
// once it holds that many commands behind the output register.
// Reset clears packet state, queue and output register; config returns to reset values.
module packet_to_flit_injector #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              push,
	output logic                              full,
	input  logic [pif_pkg::WORD_W-1:0]        data_word,
	input  logic                              first_word,
	input  logic [pif_pkg::CNT_W-1:0]         flit_count,
	input  logic [pif_pkg::ID_W-1:0]          start_flit_id,
	input  logic [pif_pkg::NUM_VC-1:0]        full_mask,

	output logic                              empty,
	input  logic                              pop,
	output logic [pif_pkg::WORD_W-1:0]        flit_word,
	output logic [pif_pkg::KIND_W-1:0]        flit_kind,
	output logic [pif_pkg::ID_W-1:0]          flit_number,
	output logic [pif_pkg::CH_W-1:0]          channel,
	output logic [pif_pkg::SLOT_W-1:0]        word_slot,
	output logic [pif_pkg::STAT_W-1:0]        status,
	output logic                              last_of_run,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pif_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pif_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pif_pkg::cfg_t  cfg_q;
	pif_pkg::cmd_t  cmd_in;
	pif_pkg::cmd_t  cmd_out;
	logic           q_full;
	logic           q_empty;
	logic           q_rd;
	logic           in_accept;

	// Accept writes every cycle; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vc_mode         <= 1'b0;
			cfg_q.fixed_channel   <= '0;
			cfg_q.active_channels <= 3'd4;
			cfg_q.words_per_flit  <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pif_pkg::REG_VC_MODE:
					cfg_q.vc_mode <= cfg_data[0];
				pif_pkg::REG_FIXED_CHANNEL:
					cfg_q.fixed_channel <= cfg_data[pif_pkg::CH_W-1:0];
				pif_pkg::REG_ACTIVE_CHANNELS:
					cfg_q.active_channels <= cfg_data[pif_pkg::ACT_W-1:0];
				pif_pkg::REG_WORDS_PER_FLIT:
					cfg_q.words_per_flit <= cfg_data[pif_pkg::WPF_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the input side off only when the command queue is full.
	assign full      = q_full;
	assign in_accept = push && !q_full;

	pif_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.accept        (in_accept),
		.data_word     (data_word),
		.first_word    (first_word),
		.flit_count    (flit_count),
		.start_flit_id (start_flit_id),
		.full_mask     (full_mask),
		.cmd           (cmd_in)
	);

	pif_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept),
		.wr_data (cmd_in),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (cmd_out),
		.empty   (q_empty)
	);

	// Advance one result beat per pop; load the next command on the last beat or when none is held.
	pif_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_data      (cmd_out),
		.q_empty     (q_empty),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.flit_word   (flit_word),
		.flit_kind   (flit_kind),
		.flit_number (flit_number),
		.channel     (channel),
		.word_slot   (word_slot),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule

// File: dv/packet_to_flit_injector_test.sv
// Self-checking testbench for packet_to_flit_injector: directed packets, then random
// packet traffic under three idle patterns, each beat checked against a built-in predictor.
// Depends on rtl/pif_pkg.sv and rtl/packet_to_flit_injector.sv.
module packet_to_flit_injector_test;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int STALL_LIMIT    = 4000;  // cycles with no beat on any channel
	localparam int DRAIN_CYCLES   = 6;     // settle time after the last expected beat
	localparam int MAX_REPORTS    = 10;
	localparam int RECONFIG_EVERY = 25;    // counted items between random settings
	localparam logic [pif_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;

	// One result beat as the block presents it.
	typedef struct packed {
		logic [pif_pkg::WORD_W-1:0] word;
		logic [pif_pkg::KIND_W-1:0] kind;
		logic [pif_pkg::ID_W-1:0]   number;
		logic [pif_pkg::CH_W-1:0]   channel;
		logic [pif_pkg::SLOT_W-1:0] slot;
		logic [pif_pkg::STAT_W-1:0] status;
		logic                       last;
	} flit_beat_t;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           push          = 1'b0;
	logic                           full;
	logic [pif_pkg::WORD_W-1:0]     data_word     = '0;
	logic                           first_word    = 1'b0;
	logic [pif_pkg::CNT_W-1:0]      flit_count    = '0;
	logic [pif_pkg::ID_W-1:0]       start_flit_id = '0;
	logic [pif_pkg::NUM_VC-1:0]     full_mask     = '0;
	logic                           empty;
	logic                           pop           = 1'b0;
	logic [pif_pkg::WORD_W-1:0]     flit_word;
	logic [pif_pkg::KIND_W-1:0]     flit_kind;
	logic [pif_pkg::ID_W-1:0]       flit_number;
	logic [pif_pkg::CH_W-1:0]       channel;
	logic [pif_pkg::SLOT_W-1:0]     word_slot;
	logic [pif_pkg::STAT_W-1:0]     status;
	logic                           last_of_run;
	logic                           cfg_valid     = 1'b0;
	logic                           cfg_ready;
	logic [pif_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [pif_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

	packet_to_flit_injector dut (.*);

	always #CLK_HALF clk = ~clk;

	// Predictor copy of the configuration registers, at their reset values.
	logic                       cfg_rr     = 1'b0;
	logic [pif_pkg::CH_W-1:0]   cfg_fixed  = '0;
	logic [pif_pkg::ACT_W-1:0]  cfg_active = 3'd4;
	logic [pif_pkg::WPF_W-1:0]  cfg_wpf    = 4'd1;

	// Predictor copy of the segmentation state.
	logic                       pkt_open    = 1'b0;
	int unsigned                flit_pos    = 0;
	int unsigned                slot_pos    = 0;
	logic [pif_pkg::CNT_W-1:0]  pkt_flits   = '0;
	logic [pif_pkg::ID_W-1:0]   pkt_base_id = '0;
	logic [pif_pkg::CH_W-1:0]   pkt_channel = '0;
	logic [pif_pkg::CH_W-1:0]   rr_last     = '0;

	flit_beat_t                 pending_flits[$];  // beats owed by the block, oldest first
	int                         fail_count     = 0;
	int                         send_idle_pct  = 0;
	int                         recv_idle_pct  = 0;
	logic [pif_pkg::STAT_W-1:0] beat_status;       // status of the first beat of the last item
	int                         quiet_cycles   = 0;

	// Segment one accepted input beat: queue the beats it yields, return their status.
	function automatic logic [pif_pkg::STAT_W-1:0] segment_beat(
			input logic [pif_pkg::WORD_W-1:0] word, input logic first,
			input logic [pif_pkg::CNT_W-1:0] count, input logic [pif_pkg::ID_W-1:0] sid,
			input logic [pif_pkg::NUM_VC-1:0] mask);
		flit_beat_t               r;
		int unsigned              wpf, n, k, c, flits;
		logic                     found;
		logic [pif_pkg::CH_W-1:0] ch;
		wpf = (cfg_wpf == 0) ? 1 :
			(cfg_wpf > pif_pkg::MAX_WPF) ? pif_pkg::MAX_WPF : cfg_wpf;
		r = '0;
		r.last = 1'b1;
		if (!pkt_open) begin
			if (!first) begin
				r.status = pif_pkg::STAT_DROP;
				pending_flits = {pending_flits, r};
				return pif_pkg::STAT_DROP;
			end
			found = 1'b0;
			ch = '0;
			if (!cfg_rr) begin
				ch = cfg_fixed;
				found = !mask[ch];
			end else begin
				// Search round-robin, starting after the channel used last.
				n = (cfg_active == 0) ? 1 :
					(cfg_active > pif_pkg::NUM_VC) ? pif_pkg::NUM_VC : cfg_active;
				for (k = 0; k < n; k++) begin
					c = (k + rr_last + 1) % n;
					if (!found && !mask[c]) begin
						ch = c[pif_pkg::CH_W-1:0];
						found = 1'b1;
					end
				end
				if (found) rr_last = ch;
			end
			if (!found) begin
				r.status = pif_pkg::STAT_STALL;
				pending_flits = {pending_flits, r};
				return pif_pkg::STAT_STALL;
			end
			flits = (count == 0) ? 1 :
				(count > pif_pkg::MAX_FLITS) ? pif_pkg::MAX_FLITS : count;
			// Head or atom flit: address word, then zero words up to the flit size.
			for (k = 0; k < wpf; k++) begin
				r.word    = (k == 0) ? word : '0;
				r.kind    = (flits == 1) ? pif_pkg::KIND_ATOM : pif_pkg::KIND_HEAD;
				r.number  = sid;
				r.channel = ch;
				r.slot    = k[pif_pkg::SLOT_W-1:0];
				r.status  = pif_pkg::STAT_OK;
				r.last    = (k + 1 == wpf);
				pending_flits = {pending_flits, r};
			end
			pkt_channel = ch;
			pkt_base_id = sid;
			pkt_flits   = flits[pif_pkg::CNT_W-1:0];
			slot_pos    = 0;
			pkt_open    = (flits > 1);
			flit_pos    = pkt_open ? 1 : 0;
			return pif_pkg::STAT_OK;
		end
		if (first) begin
			r.status = pif_pkg::STAT_DROP;
			pending_flits = {pending_flits, r};
			return pif_pkg::STAT_DROP;
		end
		if (slot_pos == 0 && mask[pkt_channel]) begin
			r.status = pif_pkg::STAT_STALL;
			pending_flits = {pending_flits, r};
			return pif_pkg::STAT_STALL;
		end
		r.word    = word;
		r.kind    = (flit_pos + 1 >= pkt_flits) ? pif_pkg::KIND_TAIL : pif_pkg::KIND_MIDDLE;
		r.number  = pkt_base_id + flit_pos;
		r.channel = pkt_channel;
		r.slot    = slot_pos[pif_pkg::SLOT_W-1:0];
		r.status  = pif_pkg::STAT_OK;
		pending_flits = {pending_flits, r};
		slot_pos++;
		if (slot_pos >= wpf) begin
			slot_pos = 0;
			flit_pos++;
			if (flit_pos >= pkt_flits) begin
				pkt_open = 1'b0;
				flit_pos = 0;
			end
		end
		return pif_pkg::STAT_OK;
	endfunction

	task automatic note_failure(input string what, input flit_beat_t want,
			input flit_beat_t got);
		if (fail_count < MAX_REPORTS) begin
			$display("%s: want word=%h kind=%0d num=%h ch=%0d slot=%0d st=%0d last=%0b",
				what, want.word, want.kind, want.number, want.channel, want.slot,
				want.status, want.last);
			$display("%s:  got word=%h kind=%0d num=%h ch=%0d slot=%0d st=%0d last=%0b",
				what, got.word, got.kind, got.number, got.channel, got.slot,
				got.status, got.last);
		end
		fail_count++;
	endtask

	// Offer one input beat; hold it until taken, then predict what it yields.
	// Leave push high so a following beat can go out back to back.
	task automatic send_beat(input logic [pif_pkg::WORD_W-1:0] word, input logic first,
			input logic [pif_pkg::CNT_W-1:0] count, input logic [pif_pkg::ID_W-1:0] sid,
			input logic [pif_pkg::NUM_VC-1:0] mask);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		data_word     <= word;
		first_word    <= first;
		flit_count    <= count;
		start_flit_id <= sid;
		full_mask     <= mask;
		do @(posedge clk); while (full);
		beat_status = segment_beat(word, first, count, sid, mask);
	endtask

	// Drop push and wait until every owed beat has come out, then let the block settle.
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_flits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers back to back, optionally poking an unused index too.
	task automatic apply_config(input logic [pif_pkg::CFG_DATA_W-1:0] mode_d,
			input logic [pif_pkg::CFG_DATA_W-1:0] fixed_d,
			input logic [pif_pkg::CFG_DATA_W-1:0] active_d,
			input logic [pif_pkg::CFG_DATA_W-1:0] wpf_d, input bit poke_unused);
		logic [pif_pkg::CFG_IDX_W-1:0]  idx [5];
		logic [pif_pkg::CFG_DATA_W-1:0] val [5];
		int                             i;
		idx = '{pif_pkg::REG_VC_MODE, REG_UNUSED, pif_pkg::REG_FIXED_CHANNEL,
			pif_pkg::REG_ACTIVE_CHANNELS, pif_pkg::REG_WORDS_PER_FLIT};
		val = '{mode_d, 8'hFF, fixed_d, active_d, wpf_d};
		wait_idle();
		for (i = 0; i < 5; i++) begin
			if (idx[i] != REG_UNUSED || poke_unused) begin
				cfg_valid <= 1'b1;
				cfg_index <= idx[i];
				cfg_data  <= val[i];
				do @(posedge clk); while (!cfg_ready);
				case (idx[i])
					pif_pkg::REG_VC_MODE:         cfg_rr     = val[i][0];
					pif_pkg::REG_FIXED_CHANNEL:   cfg_fixed  = val[i][pif_pkg::CH_W-1:0];
					pif_pkg::REG_ACTIVE_CHANNELS: cfg_active = val[i][pif_pkg::ACT_W-1:0];
					pif_pkg::REG_WORDS_PER_FLIT:  cfg_wpf    = val[i][pif_pkg::WPF_W-1:0];
					default: ;
				endcase
			end
		end
		cfg_valid <= 1'b0;
	endtask

	// Reset configuration: fixed channel 0, one word per flit.
	task automatic test_atom_and_reset();
		send_beat('1, 1'b1, 7'd1, '1, 4'hE);          // atom on channel 0
		send_beat('0, 1'b1, 7'd0, '0, 4'h0);          // count zero is one flit
		send_beat(64'h0123_4567_89AB_CDEF, 1'b0, 7'd3, 32'h5, 4'h0);  // drop: no packet
		send_beat(64'h0F0F, 1'b1, 7'd1, 32'h7, 4'h1); // stall: channel 0 full
	endtask

	// Fixed channel 3, two words per flit, flit ids wrapping through zero.
	task automatic test_fixed_channel();
		apply_config(8'h00, 8'h03, 8'h04, 8'h02, 1'b0);
		send_beat(64'hA5A5_0000_0000_0001, 1'b1, 7'd3, 32'hFFFF_FFFF, 4'h0);
		send_beat(64'h1111, 1'b0, 7'd0, '0, 4'h8);    // stall at flit start
		send_beat(64'h1111, 1'b0, 7'd0, '0, 4'h0);
		send_beat(64'h2222, 1'b0, 7'd0, '0, 4'hF);    // mid-flit: full is ignored
		send_beat(64'h3333, 1'b1, 7'd5, '0, 4'h0);    // drop: packet still open
		send_beat(64'h4444, 1'b0, 7'd0, '0, 4'h7);
		send_beat(64'h5555, 1'b0, 7'd0, '0, 4'h0);    // tail closes the packet
	endtask

	// Round-robin choice, with out-of-range counts and junk in the upper data bits.
	task automatic test_round_robin();
		apply_config(8'hAB, 8'hFC, 8'hF8, 8'hF0, 1'b1);  // one channel, one word
		send_beat(64'hBEEF, 1'b1, 7'd2, 32'h100, 4'hE);
		send_beat(64'hCAFE, 1'b0, 7'd0, '0, 4'h0);
		send_beat(64'hD00D, 1'b1, 7'd1, 32'h200, 4'h1);  // stall: only channel full
		send_beat(64'hD00D, 1'b1, 7'd1, 32'h200, 4'h0);
		apply_config(8'h01, 8'h00, 8'h07, 8'h0F, 1'b0);  // clamp to four channels, eight words
		send_beat(64'hFEED, 1'b1, 7'd1, 32'h300, 4'h2);  // skip channel 1, take 2
		send_beat(64'hFACE, 1'b1, 7'd1, 32'h400, 4'hF);  // stall: every channel full
		send_beat(64'hF00D, 1'b1, 7'd1, 32'h500, 4'h8);  // skip channel 3, wrap to 0
	endtask

	// Shrink the flit size in the middle of a flit; the flit ends on the next word.
	task automatic test_live_width();
		apply_config(8'h00, 8'h01, 8'h04, 8'h03, 1'b0);
		send_beat(64'h1, 1'b1, 7'd2, 32'h8000_0000, 4'h0);
		send_beat(64'h2, 1'b0, 7'd0, '0, 4'h0);
		send_beat(64'h3, 1'b0, 7'd0, '0, 4'h2);
		apply_config(8'h00, 8'h01, 8'h04, 8'h01, 1'b0);
		send_beat(64'h4, 1'b0, 7'd0, '0, 4'h0);
		send_beat(64'h5, 1'b0, 7'd0, '0, 4'h0);       // drop: packet closed
	endtask

	// Mostly well-formed packets with random content, a little out-of-sequence noise,
	// and a fresh random setting every RECONFIG_EVERY counted items.
	task automatic run_random_traffic(input int items, input int send_pct, input int recv_pct);
		int                             done, next_cfg, pick;
		logic                           first, mode_v;
		logic [pif_pkg::CNT_W-1:0]      count;
		logic [pif_pkg::ID_W-1:0]       sid;
		logic [pif_pkg::NUM_VC-1:0]     mask;
		logic [pif_pkg::CH_W-1:0]       fixed_v;
		logic [pif_pkg::ACT_W-1:0]      active_v;
		logic [pif_pkg::WPF_W-1:0]      wpf_v;
		logic [pif_pkg::CFG_DATA_W-1:0] junk;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		done = 0;
		next_cfg = 0;
		while (done < items) begin
			if (done >= next_cfg) begin
				mode_v   = 1'($urandom_range(1));
				fixed_v  = 2'($urandom_range(3));
				active_v = 3'($urandom_range(7));
				pick     = $urandom_range(99);
				wpf_v    = (pick < 60) ? 4'($urandom_range(3, 1)) :
					(pick < 85) ? 4'($urandom_range(8, 4)) :
					(pick < 93) ? 4'($urandom_range(15, 9)) : 4'd0;
				junk     = $urandom_range(1) ? 8'($urandom) : 8'h00;
				apply_config({junk[7:1], mode_v}, {junk[7:2], fixed_v},
					{junk[7:3], active_v}, {junk[7:4], wpf_v}, $urandom_range(7) == 0);
				next_cfg += RECONFIG_EVERY;
			end
			first = pkt_open ? ($urandom_range(99) < 6) : ($urandom_range(99) >= 6);
			pick  = $urandom_range(99);
			if (pick < 3)
				count = '0;
			else if (pick < 6 && cfg_wpf <= 2)
				count = 7'($urandom_range(127, 64));
			else if (pick < 26)
				count = 7'($urandom_range(12, 5));
			else
				count = 7'($urandom_range(4, 1));
			sid  = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom;
			mask = ($urandom_range(99) < 60) ? 4'h0 : 4'($urandom_range(15));
			send_beat({$urandom, $urandom}, first, count, sid, mask);
			// Dropped beats still yield a drop-status result beat; do not count them.
			if (beat_status != pif_pkg::STAT_DROP) done++;
		end
	endtask

	// Check each popped beat against the oldest owed beat; randomize pop for the next cycle.
	always @(posedge clk) begin : check_results
		flit_beat_t got, want;
		if (arst_n && pop && !empty) begin
			got.word    = flit_word;
			got.kind    = flit_kind;
			got.number  = flit_number;
			got.channel = channel;
			got.slot    = word_slot;
			got.status  = status;
			got.last    = last_of_run;
			if (pending_flits.size() == 0) begin
				want = '0;
				note_failure("unexpected flit beat", want, got);
			end else begin
				want = pending_flits[0];
				pending_flits.delete(0);
				if (got !== want) note_failure("flit beat mismatch", want, got);
			end
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Count cycles in which no beat moves on any channel; give up past the limit.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		// Hold reset low, then release it on a rising edge.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: light sender idling, heavy receiver stalls.
		send_idle_pct = 6;
		recv_idle_pct = 71;
		test_atom_and_reset();
		test_fixed_channel();
		test_round_robin();
		test_live_width();

		// Random part, one pass per idle pattern.
		run_random_traffic(100, 6, 71);
		run_random_traffic(100, 71, 6);
		run_random_traffic(100, 0, 0);

		// Drain, settle, and report.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_flits.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/pif_pkg.sv
rtl/pif_front.sv
rtl/pif_queue.sv
rtl/pif_back.sv
rtl/packet_to_flit_injector.sv
dv/packet_to_flit_injector_test.sv
